FILE: src/caf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caf_pkg
// Shared types, constants and helper functions of the attitude filter.
// ---------------------------------------------------------------------------
package caf_pkg;

	// CORDIC iteration count, limited to the length of the angle table
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	// square root runs one result bit per cycle
	localparam int SQRT_STEPS   = 32;

	// CORDIC vector width (magnitude growth stays below 2^34)
	localparam int CW           = 36;

	localparam logic signed [31:0] DEG90 = 32'sd5898240;

	// register map (byte address bit 2 selects the register)
	localparam logic REG_STEP_TIME   = 1'b0;
	localparam logic REG_GYRO_WEIGHT = 1'b1;

	localparam logic [19:0] STEP_TIME_RST   = 20'd83886;
	localparam logic [15:0] GYRO_WEIGHT_RST = 16'd64225;

	// multiplier operations
	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_GX,
		MOP_GY,
		MOP_GZ,
		MOP_AY,
		MOP_AZ,
		MOP_BR1,
		MOP_BR2,
		MOP_BP1,
		MOP_BP2
	} mop_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LDR,
		S_ROLL,
		S_SQRT,
		S_LDP,
		S_PITCH,
		S_BLEND,
		S_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_in;
		mop_t       mop;
		logic       cor_load_roll;
		logic       cor_load_pitch;
		logic       cor_step;
		logic [4:0] iter;
		logic       sq_start;
		logic       sq_step;
		logic       save_roll;
		logic       load_out;
	} cmd_t;

	// atan(2^-i) in 2^-16 degree, rounded
	function automatic logic [21:0] atan_deg(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -56'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

FILE: src/caf_imu_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caf_imu_if
// IMU sample channel: valid/ready plus gyro and accelerometer fields.
// ---------------------------------------------------------------------------
interface caf_imu_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		input ready);
	modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		output ready);
endinterface

FILE: src/caf_att_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caf_att_if
// Attitude result channel: valid/ready plus angles and passed-through rates.
// ---------------------------------------------------------------------------
interface caf_att_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] roll_angle;
	logic signed [31:0] pitch_angle;
	logic signed [31:0] yaw_angle;
	logic signed [15:0] roll_omega;
	logic signed [15:0] pitch_omega;
	logic signed [15:0] yaw_omega;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, roll_omega,
		pitch_omega, yaw_omega, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, roll_omega,
		pitch_omega, yaw_omega, output ready);
endinterface

FILE: src/caf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caf_ctrl
// Sequencer: integration, squares, square root, two CORDIC runs, blend.
// ---------------------------------------------------------------------------
module caf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output caf_pkg::cmd_t cmd
);
	import caf_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       ov_q, ov_d;
	logic [5:0] cnt_inc;

	assign cnt_inc   = cnt_q + 6'd1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.mop = MOP_NONE;
		cmd.iter = cnt_q[4:0];
		ov_d    = ov_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cnt_d       = '0;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				case (cnt_q[2:0])
					3'd0: cmd.mop = MOP_GX;
					3'd1: cmd.mop = MOP_GY;
					3'd2: cmd.mop = MOP_GZ;
					3'd3: cmd.mop = MOP_AY;
					3'd4: cmd.mop = MOP_AZ;
					default: cmd.mop = MOP_NONE;
				endcase
				cnt_d = cnt_inc;
				if (cnt_q == 6'd5)
					state_d = S_LDR;
			end
			S_LDR: begin
				cmd.cor_load_roll = 1'b1;
				cmd.sq_start      = 1'b1;
				cnt_d             = '0;
				state_d           = S_ROLL;
			end
			S_ROLL: begin
				cmd.cor_step = 1'b1;
				cmd.sq_step  = 1'b1;
				cnt_d        = cnt_inc;
				if (cnt_q == 6'(CSTEPS - 1))
					state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_inc;
				if (cnt_q == 6'(SQRT_STEPS - 1))
					state_d = S_LDP;
			end
			S_LDP: begin
				cmd.save_roll      = 1'b1;
				cmd.cor_load_pitch = 1'b1;
				cnt_d              = '0;
				state_d            = S_PITCH;
			end
			S_PITCH: begin
				cmd.cor_step = 1'b1;
				cnt_d        = cnt_inc;
				if (cnt_q == 6'(CSTEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_BLEND;
				end
			end
			S_BLEND: begin
				case (cnt_q[2:0])
					3'd0: cmd.mop = MOP_BR1;
					3'd1: cmd.mop = MOP_BR2;
					3'd2: cmd.mop = MOP_BP1;
					3'd3: cmd.mop = MOP_BP2;
					default: cmd.mop = MOP_NONE;
				endcase
				cnt_d = cnt_inc;
				if (cnt_q == 6'd4)
					state_d = S_DONE;
			end
			S_DONE: begin
				// hand over once the output register is free
				if (!ov_q || out_ready) begin
					cmd.load_out = 1'b1;
					ov_d         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: src/caf_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caf_dp
// Datapath: shared multiplier, bit-serial square root, shared CORDIC,
// angle estimates and the output register.
// ---------------------------------------------------------------------------
module caf_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  caf_pkg::cmd_t      cmd,
	input  logic [19:0]        step_time,
	input  logic [15:0]        gyro_weight,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic signed [31:0] roll_angle,
	output logic signed [31:0] pitch_angle,
	output logic signed [31:0] yaw_angle,
	output logic signed [15:0] roll_omega,
	output logic signed [15:0] pitch_omega,
	output logic signed [15:0] yaw_omega
);
	import caf_pkg::*;

	// sample registers
	logic signed [15:0] gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
	// estimates
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	// multiplier
	logic signed [32:0] ma;
	logic signed [20:0] mb;
	logic signed [53:0] prod_s1, acc_q;
	mop_t               mop_s1;
	logic signed [53:0] inc;
	logic signed [55:0] blend_sum;
	logic [31:0]        mag2_q;
	logic [16:0]        wc;
	// square root
	logic [63:0]        n_q, res_q, bit_q, trial;
	// CORDIC
	logic signed [CW-1:0] x_q, y_q, lx, ly, dx, dy;
	logic signed [31:0]   z_q, tab, cor_angle, roll_acc_q;
	logic                 zero_q;

	assign wc  = 17'd65536 - {1'b0, gyro_weight};
	assign inc = (prod_s1 + 54'sd2048) >>> 12;
	assign blend_sum = {{2{acc_q[53]}}, acc_q} + {{2{prod_s1[53]}}, prod_s1} + 56'sd32768;

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mop)
			MOP_GX: begin ma = 33'(gx_q); mb = $signed({1'b0, step_time}); end
			MOP_GY: begin ma = 33'(gy_q); mb = $signed({1'b0, step_time}); end
			MOP_GZ: begin ma = 33'(gz_q); mb = $signed({1'b0, step_time}); end
			MOP_AY: begin ma = 33'(ay_q); mb = 21'(ay_q); end
			MOP_AZ: begin ma = 33'(az_q); mb = 21'(az_q); end
			MOP_BR1: begin ma = 33'(roll_q); mb = $signed({5'b0, gyro_weight}); end
			MOP_BR2: begin ma = 33'(roll_acc_q); mb = $signed({4'b0, wc}); end
			MOP_BP1: begin ma = 33'(pitch_q); mb = $signed({5'b0, gyro_weight}); end
			MOP_BP2: begin ma = 33'(cor_angle); mb = $signed({4'b0, wc}); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// product register and op tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mop_s1 <= MOP_NONE;
		else
			mop_s1 <= cmd.mop;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
	end

	// estimates: integrate, then blend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
		end else begin
			case (mop_s1)
				MOP_GX: roll_q  <= sat32(56'(roll_q) + 56'(inc));
				MOP_GY: pitch_q <= sat32(56'(pitch_q) + 56'(inc));
				MOP_GZ: yaw_q   <= sat32(56'(yaw_q) + 56'(inc));
				MOP_BR2: roll_q  <= sat32(blend_sum >>> 16);
				MOP_BP2: pitch_q <= sat32(blend_sum >>> 16);
				default: ;
			endcase
		end
	end

	// squares and blend partial products
	always_ff @(posedge clk) begin
		case (mop_s1)
			MOP_AY: mag2_q <= prod_s1[31:0];
			MOP_AZ: mag2_q <= mag2_q + prod_s1[31:0];
			MOP_BR1, MOP_BP1: acc_q <= prod_s1;
			default: ;
		endcase
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			gx_q <= gyro_x;
			gy_q <= gyro_y;
			gz_q <= gyro_z;
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
		end
	end

	// square root of mag2 * 2^32, one result bit per cycle
	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_start) begin
			n_q   <= {mag2_q, 32'b0};
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sq_step) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// CORDIC operand select
	always_comb begin
		if (cmd.cor_load_pitch) begin
			ly = -$signed({{4{ax_q[15]}}, ax_q, 16'b0});
			lx = $signed({4'b0, res_q[31:0]});
		end else begin
			ly = $signed({{4{ay_q[15]}}, ay_q, 16'b0});
			lx = $signed({{4{az_q[15]}}, az_q, 16'b0});
		end
	end

	assign dx        = y_q >>> cmd.iter;
	assign dy        = x_q >>> cmd.iter;
	assign tab       = $signed({10'b0, atan_deg(cmd.iter)});
	assign cor_angle = zero_q ? 32'sd0 : z_q;

	// CORDIC vectoring: pre-rotation on load, then one iteration a cycle
	always_ff @(posedge clk) begin
		if (cmd.cor_load_roll || cmd.cor_load_pitch) begin
			zero_q <= (lx == '0) && (ly == '0);
			if (lx < 0) begin
				if (ly >= 0) begin
					x_q <= ly;
					y_q <= -lx;
					z_q <= DEG90;
				end else begin
					x_q <= -ly;
					y_q <= lx;
					z_q <= -DEG90;
				end
			end else begin
				x_q <= lx;
				y_q <= ly;
				z_q <= '0;
			end
		end else if (cmd.cor_step) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_roll)
			roll_acc_q <= cor_angle;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			roll_angle  <= roll_q;
			pitch_angle <= pitch_q;
			yaw_angle   <= yaw_q;
			roll_omega  <= gx_q;
			pitch_omega <= gy_q;
			yaw_omega   <= gz_q;
		end
	end

endmodule

FILE: src/complementary_attitude_filter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complementary_attitude_filter_core
// Gyro integration blended with accelerometer tilt from a shared CORDIC.
//
//  channel  dir  protocol    payload
//  imu      in   valid/ready 3 gyro rates, 3 accel axes (16b signed)
//  att      out  valid/ready roll/pitch/yaw (32b), 3 rates (16b)
//  apb      in   APB write   0x0 step_time, 0x4 gyro_weight
//
// A new input transfer is taken only once the previous sample has run through the
// multiplier, the square root, both CORDIC runs and the blend; the bit-serial square
// root and the shared CORDIC set the time from one input transfer to the next.
// The next sample is taken while a finished result still waits in att; a second
// finished result holds the sequencer, and the input stays closed until att drains.
// Reset clears the estimates and loads the register defaults.
// ---------------------------------------------------------------------------
module complementary_attitude_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	caf_imu_if.sink     imu,
	caf_att_if.source   att,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import caf_pkg::*;

	logic [19:0] step_q;
	logic [15:0] weight_q;
	cmd_t        cmd;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GYRO_WEIGHT) ? {16'b0, weight_q} : {12'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_TIME_RST;
			weight_q <= GYRO_WEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_STEP_TIME)
				step_q <= pwdata[19:0];
			else
				weight_q <= pwdata[15:0];
		end
	end

	caf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (imu.valid),
		.in_ready  (imu.ready),
		.out_ready (att.ready),
		.out_valid (att.valid),
		.cmd       (cmd)
	);

	caf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.step_time   (step_q),
		.gyro_weight (weight_q),
		.gyro_x      (imu.gyro_x),
		.gyro_y      (imu.gyro_y),
		.gyro_z      (imu.gyro_z),
		.accel_x     (imu.accel_x),
		.accel_y     (imu.accel_y),
		.accel_z     (imu.accel_z),
		.roll_angle  (att.roll_angle),
		.pitch_angle (att.pitch_angle),
		.yaw_angle   (att.yaw_angle),
		.roll_omega  (att.roll_omega),
		.pitch_omega (att.pitch_omega),
		.yaw_omega   (att.yaw_omega)
	);

	// a transfer in closes the input until the sample is done
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		imu.valid && imu.ready |=> !imu.ready)
		else $error("input ready stayed high after a transfer");

	// no CORDIC iteration while idle
	a_cor_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cor_step |-> !imu.ready)
		else $error("CORDIC stepping while idle");

	// the output register is loaded only when free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!att.valid || att.ready))
		else $error("result overwritten before transfer");

endmodule
